>>> hw/rtl/mlp_bp_pkg.sv
`default_nettype none
package mlp_bp_pkg;

    localparam int SIG_ENTRIES = 256;
    localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);
    localparam int NUM_PARAMS  = 9;
    localparam int PAR_IDX_W   = 4;
    localparam int ONE_Q       = 4096;
    localparam int OPW         = 24;
    localparam int ACCW        = 32;
    localparam int MIDW        = 22;

    typedef logic signed [15:0]     q16_t;
    typedef logic [12:0]            prob_t;
    typedef logic signed [MIDW-1:0] mid_t;
    typedef prob_t sig_lut_t [SIG_ENTRIES];

    typedef struct packed {
        logic signed [OPW-1:0]  a;
        logic signed [OPW-1:0]  b;
        logic signed [ACCW-1:0] addend;
    } mac_req_t;

    // shift-and-subtract quotient, only used while the constant table is built
    function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // 4096/(1+e^-x) from a truncated series for e^|x|, rounded to nearest
    function automatic sig_lut_t build_lut();
        sig_lut_t          lut;
        longint            num;
        longint unsigned   a;
        longint unsigned   one;
        longint unsigned   term;
        longint unsigned   e;
        longint unsigned   d;
        for (int k = 0; k < SIG_ENTRIES; k++) begin
            num  = 16 * longint'(k) - 8 * longint'(SIG_ENTRIES);
            a    = (num < 0) ? longint'(-num) : longint'(num);
            one  = 64'd1 << 32;
            term = one;
            e    = one;
            for (int i = 1; i <= 80; i++) begin
                term = udiv64(term * a, 64'(SIG_ENTRIES * i));
                e    = e + term;
            end
            d = e + one;
            if (num < 0) lut[k] = 13'(udiv64((64'd1 << 44) + (d >> 1), d));
            else         lut[k] = 13'(udiv64(64'(ONE_Q) * e + (d >> 1), d));
        end
        return lut;
    endfunction

    localparam sig_lut_t SIG_LUT = build_lut();

    function automatic q16_t sat16(logic signed [ACCW-1:0] v);
        if (v > ACCW'(32767))       return 16'sh7fff;
        else if (v < -ACCW'(32768)) return 16'sh8000;
        else                        return v[15:0];
    endfunction

    function automatic prob_t sigmoid(logic signed [ACCW-1:0] s);
        q16_t        c;
        logic [31:0] t;
        c = sat16(s);
        t = 32'({~c[15], c[14:0]}) * 32'(SIG_ENTRIES);
        return SIG_LUT[t[16 +: SIG_IDX_W]];
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/mlp_bp_mac.sv
`default_nettype none
module mlp_bp_mac
    import mlp_bp_pkg::*;
(
    input  wire mac_req_t               req,
    output logic signed [ACCW-1:0]      sum
);
    logic signed [2*OPW-1:0] prod;
    logic signed [2*OPW-1:0] q;

    always_comb begin
        prod = req.a * req.b;
        q    = prod >>> 12;
        sum  = req.addend + q[ACCW-1:0];
    end
endmodule
`default_nettype wire

>>> hw/rtl/mlp_2_2_1_backprop_step_core.sv
`default_nettype none
// 2-2-1 sigmoid perceptron in Q4.12 with one backpropagation step per train item.
// All products go through one shared multiply-accumulate unit stepped by a
// sequencer, one product per cycle. An accepted item runs through the
// inference steps, for training also the backpropagation steps, or none for a
// parameter write or read, then into the output register, which waits there
// while an earlier result is still held. s_ready is high only while the
// sequencer idles, so the core takes no new item before it is through with the
// last one. Parameters reset to zero, learning rate to 819.
module mlp_2_2_1_backprop_step_core
    import mlp_bp_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              cfg_we,
    input  wire  [14:0]      cfg_wdata,
    input  wire              s_valid,
    output logic             s_ready,
    input  wire  [1:0]       s_kind,
    input  wire  signed [15:0] s_in_a,
    input  wire  signed [15:0] s_in_b,
    input  wire  [12:0]      s_target,
    input  wire  [3:0]       s_param_index,
    input  wire  signed [15:0] s_param_value,
    output logic             m_valid,
    input  wire              m_ready,
    output logic [12:0]      m_prediction,
    output logic signed [15:0] m_param_read
);
    localparam logic [1:0] K_INFER = 2'd0;
    localparam logic [1:0] K_TRAIN = 2'd1;
    localparam logic [1:0] K_WRITE = 2'd2;
    localparam logic [1:0] K_READ  = 2'd3;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_F0   = 5'd1;
    localparam logic [4:0] S_F8   = 5'd9;
    localparam logic [4:0] S_T0   = 5'd10;
    localparam logic [4:0] S_T19  = 5'd29;
    localparam logic [4:0] S_FIN  = 5'd30;

    localparam logic [3:0] D_NONE = 4'd0;
    localparam logic [3:0] D_ACC  = 4'd1;
    localparam logic [3:0] D_H0   = 4'd2;
    localparam logic [3:0] D_H1   = 4'd3;
    localparam logic [3:0] D_O    = 4'd4;
    localparam logic [3:0] D_T1   = 4'd5;
    localparam logic [3:0] D_T2   = 4'd6;
    localparam logic [3:0] D_G    = 4'd7;
    localparam logic [3:0] D_EH0  = 4'd8;
    localparam logic [3:0] D_EH1  = 4'd9;
    localparam logic [3:0] D_GH   = 4'd10;
    localparam logic [3:0] D_PAR  = 4'd11;

    logic [4:0]  state_reg, state_next;
    q16_t        store_reg [NUM_PARAMS];
    logic [14:0] lr_reg;
    logic [1:0]  kind_reg;
    q16_t        x0_reg, x1_reg, pval_reg;
    logic [12:0] tgt_reg;
    logic [PAR_IDX_W-1:0] idx_reg;
    prob_t       h0_reg, h1_reg, o_reg;
    mid_t        t1_reg, t2_reg, g_reg, eh0_reg, eh1_reg, gh_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic        m_valid_reg;
    logic [12:0] pred_reg;
    q16_t        pread_reg;

    logic [PAR_IDX_W-1:0]   rd_addr;
    q16_t                   par_rd;
    logic [3:0]             dst;
    mac_req_t               req;
    logic signed [ACCW-1:0] sum;
    logic signed [13:0]     err;
    logic                   out_free;

    function automatic logic signed [OPW-1:0] ext_u(prob_t v);
        return OPW'($signed({1'b0, v}));
    endfunction

    mlp_bp_mac u_mac (.req(req), .sum(sum));

    assign par_rd   = (rd_addr < PAR_IDX_W'(NUM_PARAMS)) ? store_reg[rd_addr] : '0;
    assign err      = $signed({1'b0, tgt_reg}) - $signed({1'b0, o_reg});
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    assign m_valid      = m_valid_reg;
    assign m_prediction = pred_reg;
    assign m_param_read = pread_reg;

    // micro-step decode: operands, addend, destination and next state of each step
    always_comb begin
        rd_addr    = idx_reg;
        dst        = D_NONE;
        req.a      = OPW'(par_rd);
        req.b      = OPW'(ONE_Q);
        req.addend = '0;
        state_next = (state_reg == S_FIN || state_reg == S_IDLE) ? state_reg
                                                                  : state_reg + 5'd1;
        unique case (state_reg)
            S_F0:  begin rd_addr = 4'd0; req.b = OPW'(x0_reg); dst = D_ACC; end
            5'd2:  begin rd_addr = 4'd1; req.b = OPW'(x1_reg); req.addend = acc_reg;
                         dst = D_ACC; end
            5'd3:  begin rd_addr = 4'd6; req.addend = acc_reg; dst = D_H0; end
            5'd4:  begin rd_addr = 4'd2; req.b = OPW'(x0_reg); dst = D_ACC; end
            5'd5:  begin rd_addr = 4'd3; req.b = OPW'(x1_reg); req.addend = acc_reg;
                         dst = D_ACC; end
            5'd6:  begin rd_addr = 4'd7; req.addend = acc_reg; dst = D_H1; end
            5'd7:  begin rd_addr = 4'd4; req.b = ext_u(h0_reg); dst = D_ACC; end
            5'd8:  begin rd_addr = 4'd5; req.b = ext_u(h1_reg); req.addend = acc_reg;
                         dst = D_ACC; end
            S_F8:  begin rd_addr = 4'd8; req.addend = acc_reg; dst = D_O;
                         state_next = (kind_reg == K_TRAIN) ? S_T0 : S_FIN; end
            S_T0:  begin req.a = OPW'($signed({1'b0, lr_reg})); req.b = OPW'(err);
                         dst = D_T1; end
            5'd11: begin req.a = ext_u(o_reg); req.b = ext_u(13'(ONE_Q) - o_reg);
                         dst = D_T2; end
            5'd12: begin req.a = OPW'(t1_reg); req.b = OPW'(t2_reg); dst = D_G; end
            5'd13: begin rd_addr = 4'd4; req.b = OPW'(err); dst = D_EH0; end
            5'd14: begin rd_addr = 4'd5; req.b = OPW'(err); dst = D_EH1; end
            5'd15: begin rd_addr = 4'd4; req.a = OPW'(g_reg); req.b = ext_u(h0_reg);
                         req.addend = ACCW'(par_rd); dst = D_PAR; end
            5'd16: begin rd_addr = 4'd5; req.a = OPW'(g_reg); req.b = ext_u(h1_reg);
                         req.addend = ACCW'(par_rd); dst = D_PAR; end
            5'd17: begin rd_addr = 4'd8; req.a = OPW'(g_reg);
                         req.addend = ACCW'(par_rd); dst = D_PAR; end
            5'd18: begin req.a = OPW'($signed({1'b0, lr_reg})); req.b = OPW'(eh0_reg);
                         dst = D_T1; end
            5'd19: begin req.a = ext_u(h0_reg); req.b = ext_u(13'(ONE_Q) - h0_reg);
                         dst = D_T2; end
            5'd20: begin req.a = OPW'(t1_reg); req.b = OPW'(t2_reg); dst = D_GH; end
            5'd21: begin rd_addr = 4'd0; req.a = OPW'(gh_reg); req.b = OPW'(x0_reg);
                         req.addend = ACCW'(par_rd); dst = D_PAR; end
            5'd22: begin rd_addr = 4'd1; req.a = OPW'(gh_reg); req.b = OPW'(x1_reg);
                         req.addend = ACCW'(par_rd); dst = D_PAR; end
            5'd23: begin rd_addr = 4'd6; req.a = OPW'(gh_reg);
                         req.addend = ACCW'(par_rd); dst = D_PAR; end
            5'd24: begin req.a = OPW'($signed({1'b0, lr_reg})); req.b = OPW'(eh1_reg);
                         dst = D_T1; end
            5'd25: begin req.a = ext_u(h1_reg); req.b = ext_u(13'(ONE_Q) - h1_reg);
                         dst = D_T2; end
            5'd26: begin req.a = OPW'(t1_reg); req.b = OPW'(t2_reg); dst = D_GH; end
            5'd27: begin rd_addr = 4'd2; req.a = OPW'(gh_reg); req.b = OPW'(x0_reg);
                         req.addend = ACCW'(par_rd); dst = D_PAR; end
            5'd28: begin rd_addr = 4'd3; req.a = OPW'(gh_reg); req.b = OPW'(x1_reg);
                         req.addend = ACCW'(par_rd); dst = D_PAR; end
            S_T19: begin rd_addr = 4'd7; req.a = OPW'(gh_reg);
                         req.addend = ACCW'(par_rd); dst = D_PAR;
                         state_next = S_FIN; end
            default: begin
                if (state_reg == S_IDLE && s_valid) begin
                    state_next = (s_kind == K_INFER || s_kind == K_TRAIN) ? S_F0 : S_FIN;
                end else if (state_reg == S_FIN && out_free) begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            lr_reg      <= 15'd819;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PARAMS; i++) store_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) lr_reg <= cfg_wdata;
            if (dst == D_PAR) store_reg[rd_addr] <= sat16(sum);
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
                if (kind_reg == K_WRITE && idx_reg < PAR_IDX_W'(NUM_PARAMS)) begin
                    store_reg[idx_reg] <= pval_reg;
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            kind_reg <= s_kind;
            x0_reg   <= s_in_a;
            x1_reg   <= s_in_b;
            tgt_reg  <= s_target;
            idx_reg  <= s_param_index;
            pval_reg <= s_param_value;
        end
        unique case (dst)
            D_ACC:   acc_reg <= sum;
            D_H0:    h0_reg  <= sigmoid(sum);
            D_H1:    h1_reg  <= sigmoid(sum);
            D_O:     o_reg   <= sigmoid(sum);
            D_T1:    t1_reg  <= MIDW'(sum);
            D_T2:    t2_reg  <= MIDW'(sum);
            D_G:     g_reg   <= MIDW'(sum);
            D_EH0:   eh0_reg <= MIDW'(sum);
            D_EH1:   eh1_reg <= MIDW'(sum);
            D_GH:    gh_reg  <= MIDW'(sum);
            default: ;
        endcase
        if (state_reg == S_FIN && out_free) begin
            pred_reg  <= (kind_reg == K_INFER || kind_reg == K_TRAIN) ? o_reg : '0;
            pread_reg <= (kind_reg == K_READ) ? par_rd : '0;
        end
    end
endmodule
`default_nettype wire
